### sv/source_line_tokenizer_assert.svh
// Assertion macros used by the tokenizer top level.
`ifndef SOURCE_LINE_TOKENIZER_ASSERT_SVH
`define SOURCE_LINE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/slt_pkg.sv
// Types, character codes and the per-character classification step of the tokenizer.
package slt_pkg;

    // Event codes carried on event_res.
    localparam logic [1:0] EV_APPEND  = 2'd0;
    localparam logic [1:0] EV_CLOSE   = 2'd1;
    localparam logic [1:0] EV_STR_ERR = 2'd2;
    localparam logic [1:0] EV_ESC_ERR = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Event list sizing and the record queue depth.
    localparam int MAX_EV  = 8;
    localparam int IDX_W   = $clog2(MAX_EV);
    localparam int CNT_W   = $clog2(MAX_EV + 1);
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam logic [15:0] COL_OUT_MAX = 16'hFFFF;

    // One event of a record; off is the column advance within the item.
    typedef struct packed {
        logic [1:0] code;
        logic [7:0] ch;
        logic [1:0] off;
    } lev_t;

    // Lexer flags kept by the front part.
    typedef struct packed {
        logic [7:0] held_char;
        logic       held_valid;
        logic       in_string;
        logic       escape_pending;
        logic       token_nonempty;
        logic       comment_skip;
        logic       halted;
    } lex_state_t;

    // Scratch value built up while one character is classified.
    typedef struct packed {
        lex_state_t              st;
        lev_t [MAX_EV-1:0]       evs;
        logic [CNT_W-1:0]        n;
        logic [1:0]              off;
        logic                    col_clear;
    } lex_work_t;

    // Record passed from the front part to the back part.
    typedef struct packed {
        lev_t [MAX_EV-1:0] evs;
        logic [CNT_W-1:0]  n;
        logic [15:0]       line;
    } lex_rec_t;

    function automatic logic is_pair(logic [7:0] c);
        return c == CH_COLON || c == CH_PLUS || c == CH_MINUS || c == CH_LT ||
               c == CH_GT || c == CH_EQ || c == CH_AMP || c == CH_BAR;
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE ||
               c == CH_AMP || c == CH_COMMA || c == CH_SEMI || c == CH_COLON ||
               c == CH_QMARK || c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
               c == CH_SLASH || c == CH_PCT;
    endfunction

    function automatic lex_work_t emit(lex_work_t w, logic [1:0] code, logic [7:0] ch);
        lex_work_t r;
        r = w;
        r.evs[w.n[IDX_W-1:0]].code = code;
        r.evs[w.n[IDX_W-1:0]].ch   = ch;
        r.evs[w.n[IDX_W-1:0]].off  = w.off;
        r.n = w.n + CNT_W'(1);
        return r;
    endfunction

    function automatic lex_work_t col_inc(lex_work_t w);
        lex_work_t r;
        r = w;
        r.off = w.off + 2'd1;
        return r;
    endfunction

    function automatic lex_work_t close_tok(lex_work_t w);
        lex_work_t r;
        r = w;
        if (r.st.token_nonempty)
        begin
            r = emit(r, EV_CLOSE, 8'd0);
        end
        r.st.token_nonempty = 1'b0;
        return r;
    endfunction

    function automatic lex_work_t append(lex_work_t w, logic [7:0] ch);
        lex_work_t r;
        r = emit(w, EV_APPEND, ch);
        r.st.token_nonempty = 1'b1;
        return r;
    endfunction

    function automatic lex_work_t single(lex_work_t w, logic [7:0] ch);
        lex_work_t r;
        r = close_tok(w);
        r = append(r, ch);
        r = close_tok(r);
        return r;
    endfunction

    function automatic lex_work_t fail(lex_work_t w, logic [1:0] code);
        lex_work_t r;
        r = emit(w, code, 8'd0);
        r.st.halted = 1'b1;
        return r;
    endfunction

    function automatic lex_work_t line_reset(lex_work_t w);
        lex_work_t r;
        r = w;
        r.st.held_valid     = 1'b0;
        r.st.in_string      = 1'b0;
        r.st.escape_pending = 1'b0;
        r.st.token_nonempty = 1'b0;
        r.st.comment_skip   = 1'b0;
        r.col_clear         = 1'b1;
        return r;
    endfunction

    function automatic lex_work_t classify(lex_work_t w, logic [7:0] c);
        lex_work_t r;
        if (is_punct(c))
        begin
            r = single(w, c);
        end
        else if (c == CH_NL || c == CH_TAB || c == CH_SPACE)
        begin
            r = close_tok(w);
        end
        else
        begin
            r = append(w, c);
        end
        return r;
    endfunction

    // A character that is not resolving a held one.
    function automatic lex_work_t fresh(lex_work_t w, logic [7:0] ch, logic le);
        lex_work_t r;
        r = w;
        if (r.st.escape_pending)
        begin
            if (le)
            begin
                r = fail(r, EV_ESC_ERR);
            end
            else
            begin
                r.st.escape_pending = 1'b0;
                r = append(r, ch);
                r = col_inc(r);
                r = close_tok(r);
                r = col_inc(r);
            end
        end
        else if (r.st.in_string)
        begin
            if (ch == CH_BSLASH)
            begin
                r = close_tok(r);
                r = append(r, ch);
                if (le)
                begin
                    r = fail(r, EV_ESC_ERR);
                end
                else
                begin
                    r.st.escape_pending = 1'b1;
                end
            end
            else
            begin
                if (ch == CH_DQUOTE)
                begin
                    r = single(r, ch);
                    r.st.in_string = 1'b0;
                end
                else
                begin
                    r = append(r, ch);
                end
                r = col_inc(r);
                if (le)
                begin
                    if (r.st.in_string)
                    begin
                        r = fail(r, EV_STR_ERR);
                    end
                    else
                    begin
                        r = line_reset(r);
                    end
                end
            end
        end
        else if (ch == CH_DQUOTE)
        begin
            r = single(r, ch);
            r.st.in_string = 1'b1;
            r = col_inc(r);
            if (le)
            begin
                r = fail(r, EV_STR_ERR);
            end
        end
        else if (!le && (ch == CH_SLASH || is_pair(ch)))
        begin
            r.st.held_char  = ch;
            r.st.held_valid = 1'b1;
        end
        else
        begin
            r = classify(r, ch);
            if (le)
            begin
                r = close_tok(r);
                r = line_reset(r);
            end
            else
            begin
                r = col_inc(r);
            end
        end
        return r;
    endfunction

    // Whole classification of one accepted character.
    function automatic lex_work_t lex_step(lex_state_t s, logic [7:0] ch, logic le);
        lex_work_t  w;
        logic [7:0] h;
        w    = '0;
        w.st = s;
        h    = s.held_char;
        if (s.halted)
        begin
            w.st = s;
        end
        else if (s.comment_skip)
        begin
            if (le)
            begin
                w = line_reset(w);
            end
        end
        else if (s.held_valid)
        begin
            w.st.held_valid = 1'b0;
            if (h == CH_SLASH && ch == CH_SLASH)
            begin
                w = close_tok(w);
                if (le)
                begin
                    w = line_reset(w);
                end
                else
                begin
                    w.st.comment_skip = 1'b1;
                end
            end
            else if (is_pair(h) && ch == h)
            begin
                w = append(w, h);
                w = append(w, h);
                w = col_inc(w);
                w = close_tok(w);
                w = col_inc(w);
                if (le)
                begin
                    w = line_reset(w);
                end
            end
            else
            begin
                w = classify(w, h);
                w = col_inc(w);
                w = fresh(w, ch, le);
            end
        end
        else
        begin
            w = fresh(w, ch, le);
        end
        return w;
    endfunction

endpackage

### sv/slt_front.sv
// Front part: accepts characters, keeps the lexer state and builds one event record each.
module slt_front #(
    parameter int COLUMN_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               chr,
    input  logic                     line_end,
    input  logic [15:0]              line_number,
    input  logic                     push,
    input  logic                     q_full,
    output logic                     q_push,
    output slt_pkg::lex_rec_t        q_rec,
    output logic [COLUMN_BITS-1:0]   q_col
);
    import slt_pkg::*;

    lex_state_t             st_reg, st_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    lex_work_t              work;
    logic                   accept;
    logic [COLUMN_BITS:0]   col_sum;

    // Classify the offered character against the current state.
    always_comb
    begin
        accept  = push && !q_full;
        work    = lex_step(st_reg, chr, line_end);
        col_sum = {1'b0, col_reg} + (COLUMN_BITS + 1)'(work.off);
        st_next  = st_reg;
        col_next = col_reg;
        if (accept)
        begin
            st_next = work.st;
            if (work.col_clear)
            begin
                col_next = '0;
            end
            else if (col_sum[COLUMN_BITS])
            begin
                col_next = '1;
            end
            else
            begin
                col_next = col_sum[COLUMN_BITS-1:0];
            end
        end
    end

    // A record goes to the queue only when the item gives at least one event.
    always_comb
    begin
        q_push     = accept && (work.n != '0);
        q_rec.evs  = work.evs;
        q_rec.n    = work.n;
        q_rec.line = line_number;
        q_col      = col_reg;
    end

    // Lexer state and column counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            col_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            col_reg <= col_next;
        end
    end

endmodule

### sv/slt_queue.sv
// Short record queue between the front and back parts.
module slt_queue #(
    parameter int COLUMN_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  slt_pkg::lex_rec_t        rec_in,
    input  logic [COLUMN_BITS-1:0]   col_in,
    output logic                     full,
    input  logic                     pop,
    output slt_pkg::lex_rec_t        head_rec,
    output logic [COLUMN_BITS-1:0]   head_col,
    output logic                     nonempty
);
    import slt_pkg::*;

    lex_rec_t               rec_mem [QDEPTH];
    logic [COLUMN_BITS-1:0] col_mem [QDEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]      count_reg, count_next;
    logic                   do_push, do_pop;

    // Status and head entry.
    always_comb
    begin
        full     = (count_reg == QCNT_W'(QDEPTH));
        nonempty = (count_reg != '0);
        head_rec = rec_mem[rd_ptr_reg];
        head_col = col_mem[rd_ptr_reg];
    end

    // Pointer and fill count update.
    always_comb
    begin
        do_push     = push && !full;
        do_pop      = pop && nonempty;
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            rec_mem[wr_ptr_reg] <= rec_in;
            col_mem[wr_ptr_reg] <= col_in;
        end
    end

endmodule

### sv/slt_back.sv
// Back part: walks the events of the head record into the output register one per cycle while it is free or popped.
module slt_back #(
    parameter int COLUMN_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  slt_pkg::lex_rec_t        head_rec,
    input  logic [COLUMN_BITS-1:0]   head_col,
    input  logic                     q_nonempty,
    output logic                     q_pop,
    input  logic                     pop,
    output logic                     empty,
    output logic [1:0]               event_res,
    output logic [7:0]               out_char,
    output logic [15:0]              line,
    output logic [15:0]              column,
    output logic                     last
);
    import slt_pkg::*;

    localparam int WIDE_W = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;

    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   valid_reg, valid_next;
    logic [1:0]             event_reg, event_next;
    logic [7:0]             char_reg, char_next;
    logic [15:0]            line_reg, line_next;
    logic [15:0]            column_reg, column_next;
    logic                   last_reg, last_next;
    lev_t                   ev;
    logic                   load, ev_last;
    logic [COLUMN_BITS:0]   col_sum;
    logic [COLUMN_BITS-1:0] col_sat;
    logic [WIDE_W-1:0]      col_wide;

    // Column of the current event: saturate at the counter width, then clip to the port.
    always_comb
    begin
        ev       = head_rec.evs[idx_reg];
        col_sum  = {1'b0, head_col} + (COLUMN_BITS + 1)'(ev.off);
        col_sat  = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
        col_wide = WIDE_W'(col_sat);
    end

    // Load the output register whenever a record waits and the register is free or being taken.
    always_comb
    begin
        load    = q_nonempty && (!valid_reg || pop);
        ev_last = (CNT_W'(idx_reg) + CNT_W'(1)) == head_rec.n;
        q_pop   = load && ev_last;

        idx_next    = idx_reg;
        valid_next  = valid_reg && !pop;
        event_next  = event_reg;
        char_next   = char_reg;
        line_next   = line_reg;
        column_next = column_reg;
        last_next   = last_reg;
        if (load)
        begin
            idx_next    = ev_last ? '0 : idx_reg + IDX_W'(1);
            valid_next  = 1'b1;
            event_next  = ev.code;
            char_next   = ev.ch;
            line_next   = head_rec.line;
            column_next = (col_wide > WIDE_W'(COL_OUT_MAX)) ? COL_OUT_MAX : col_wide[15:0];
            last_next   = ev_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge clk)
    begin
        event_reg  <= event_next;
        char_reg   <= char_next;
        line_reg   <= line_next;
        column_reg <= column_next;
        last_reg   <= last_next;
    end

    assign empty     = !valid_reg;
    assign event_res = event_reg;
    assign out_char  = char_reg;
    assign line      = line_reg;
    assign column    = column_reg;
    assign last      = last_reg;

endmodule

### sv/source_line_tokenizer.sv
// Top level of the source line tokenizer.
//
//  Channel  Direction  Handshake           Payload
//  input    in         push / full         chr, line_end, line_number
//  result   out        pop / empty         event_res, out_char, line, column, last
//
// The front takes one character per cycle while the record queue has room.
// The back sends one event per cycle while its output register is free or popped, and
// stays on an item until all its events are sent; an item with no event puts no record
// into the queue. The first event of an item passes through the record queue and then
// the output register. full rises with QDEPTH records waiting; pop low holds the output.
// Reset clears all lexer state, the queue pointers and the output valid flag at once.
`include "source_line_tokenizer_assert.svh"

module source_line_tokenizer #(
    parameter int COLUMN_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  chr,
    input  logic        line_end,
    input  logic [15:0] line_number,
    input  logic        push,
    output logic        full,
    output logic [1:0]  event_res,
    output logic [7:0]  out_char,
    output logic [15:0] line,
    output logic [15:0] column,
    output logic        last,
    output logic        empty,
    input  logic        pop
);
    import slt_pkg::*;

    logic                   q_push, q_full, q_pop, q_nonempty;
    lex_rec_t               front_rec, head_rec;
    logic [COLUMN_BITS-1:0] front_col, head_col;

    // Character classification and lexer state.
    slt_front #(.COLUMN_BITS(COLUMN_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .chr         (chr),
        .line_end    (line_end),
        .line_number (line_number),
        .push        (push),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (front_rec),
        .q_col       (front_col)
    );

    // Records waiting for the back part.
    slt_queue #(.COLUMN_BITS(COLUMN_BITS)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .rec_in   (front_rec),
        .col_in   (front_col),
        .full     (q_full),
        .pop      (q_pop),
        .head_rec (head_rec),
        .head_col (head_col),
        .nonempty (q_nonempty)
    );

    // Event expansion and output register.
    slt_back #(.COLUMN_BITS(COLUMN_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_rec   (head_rec),
        .head_col   (head_col),
        .q_nonempty (q_nonempty),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .event_res  (event_res),
        .out_char   (out_char),
        .line       (line),
        .column     (column),
        .last       (last)
    );

    assign full = q_full;

    // A queued record always carries between one and MAX_EV events.
    `SLT_ASSERT_NOW(a_rec_count, q_push,
        (front_rec.n != '0) && (front_rec.n <= CNT_W'(MAX_EV)), "record event count out of range")
    // The front never writes a record into a full queue.
    `SLT_ASSERT_NOW(a_no_overflow, q_push, !q_full, "record pushed while queue full")
    // A record leaves the queue exactly when its final event enters the output register.
    `SLT_ASSERT_NEXT(a_pop_on_last, q_pop, !empty && last, "record retired without final event")

endmodule
